[hw/rtl/lgge_pkg.sv]
package lgge_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_LOW    = 4'd2;
    localparam logic [3:0] KEEP_HIGH   = 4'd3;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_UP,
        ST_RD_CUR,
        ST_RD_DN,
        ST_WR_ROW,
        ST_ZERO_ROW
    } lgge_state_t;

endpackage

[hw/rtl/lgge_ram.sv]
module lgge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [WIDTH-1:0]           wmask,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lgge_row_next.sv]
module lgge_row_next #(
    parameter int MAX_COLS = 32
) (
    input  logic [MAX_COLS-1:0]            up_row,
    input  logic [MAX_COLS-1:0]            cur_row,
    input  logic [MAX_COLS-1:0]            dn_row,
    input  logic [$clog2(MAX_COLS+1)-1:0]  eff_cols,
    output logic [MAX_COLS-1:0]            nxt_row
);

    import lgge_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    logic [CW-1:0]       last_col;
    logic [MAX_COLS-1:0] up_l, up_r, cur_l, cur_r, dn_l, dn_r;
    logic [3:0]          cnt [MAX_COLS];

    function automatic logic [MAX_COLS-1:0] wrap_lft(input logic [MAX_COLS-1:0] r,
                                                    input logic [CW-1:0] last);
        wrap_lft = {r[MAX_COLS-2:0], r[last]};
    endfunction

    function automatic logic [MAX_COLS-1:0] wrap_rgt(input logic [MAX_COLS-1:0] r,
                                                    input logic [CW-1:0] last);
        logic [MAX_COLS-1:0] v;
        v       = {1'b0, r[MAX_COLS-1:1]};
        v[last] = r[0];
        wrap_rgt = v;
    endfunction

    function automatic logic [3:0] b2n(input logic b);
        b2n = {3'b000, b};
    endfunction

    assign last_col = CW'(eff_cols - 1'b1);

    always_comb
    begin
        up_l  = wrap_lft(up_row, last_col);
        up_r  = wrap_rgt(up_row, last_col);
        cur_l = wrap_lft(cur_row, last_col);
        cur_r = wrap_rgt(cur_row, last_col);
        dn_l  = wrap_lft(dn_row, last_col);
        dn_r  = wrap_rgt(dn_row, last_col);
    end

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt[c] = b2n(up_l[c]) + b2n(up_row[c]) + b2n(up_r[c])
                   + b2n(cur_l[c]) + b2n(cur_r[c])
                   + b2n(dn_l[c]) + b2n(dn_row[c]) + b2n(dn_r[c]);
            if (32'(c) >= 32'(eff_cols))
            begin
                nxt_row[c] = 1'b0;
            end
            else if (cur_row[c])
            begin
                nxt_row[c] = (cnt[c] == KEEP_LOW) || (cnt[c] == KEEP_HIGH);
            end
            else
            begin
                nxt_row[c] = (cnt[c] == BIRTH_COUNT);
            end
        end
    end

endmodule

[hw/rtl/life_grid_generation_engine_unit.sv]
// Cell write and read: back to back, one per cycle when idle; result the cycle after accept.
// Advance: RD_UP, RD_CUR, RD_DN, WR_ROW per row in use; ZERO_ROW per unused row up to MAX_ROWS;
//   result strobe the cycle after the last row is written (one RAM read port, three reads a row).
// Error results (bad address, zero size, unused func) come the cycle after accept.
// Reset: asynchronous; a clearing sweep of 2*MAX_ROWS words zeroes both banks, busy held high.
// Results are strobed for one cycle and cannot be stalled.
module life_grid_generation_engine_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [3:0]  row,
    input  logic [4:0]  col,
    input  logic        cell_in,
    output logic        done,
    output logic        cell_out,
    output logic        status
);

    import lgge_pkg::*;

    localparam int DEPTH = 2 * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int ERW   = $clog2(MAX_ROWS + 1);
    localparam int ECW   = $clog2(MAX_COLS + 1);

    lgge_state_t st_reg, st_next;

    logic [4:0]          rows_in_use_reg;
    logic [5:0]          cols_in_use_reg;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [MAX_COLS-1:0] up_reg, up_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic                active_reg, active_next;
    logic                done_reg, done_next;
    logic                status_reg, status_next;
    logic                rd_reg, rd_next;
    logic [CW-1:0]       col_reg, col_next;

    logic [ERW-1:0]      eff_rows;
    logic [ECW-1:0]      eff_cols;
    logic                accept;
    logic                acc_err;
    logic                addr_ok;
    logic                cfg_wr;
    logic [RW-1:0]       last_row, up_row, dn_row;
    logic                row_in_use, nxt_in_use, row_last;
    logic [MAX_COLS-1:0] calc_row;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [MAX_COLS-1:0] ram_wdata, ram_wmask, ram_rdata;

    function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [RW-1:0] r);
        bank_addr = bank ? AW'(MAX_ROWS) + AW'(r) : AW'(r);
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_in_use_reg) : 32'(rows_in_use_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= 5'd10;
            cols_in_use_reg <= 6'd30;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROWS: rows_in_use_reg <= pwdata[4:0];
                REG_COLS: cols_in_use_reg <= pwdata[5:0];
                default:  rows_in_use_reg <= rows_in_use_reg;
            endcase
        end
    end

    assign eff_rows = (32'(rows_in_use_reg) > MAX_ROWS) ? ERW'(MAX_ROWS) : ERW'(rows_in_use_reg);
    assign eff_cols = (32'(cols_in_use_reg) > MAX_COLS) ? ECW'(MAX_COLS) : ECW'(cols_in_use_reg);

    assign busy    = (st_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign addr_ok = (32'(row) < 32'(eff_rows)) && (32'(col) < 32'(eff_cols));

    always_comb
    begin
        unique case (func)
            FUNC_WRITE: acc_err = !addr_ok;
            FUNC_READ:  acc_err = !addr_ok;
            FUNC_STEP:  acc_err = (eff_rows == '0) || (eff_cols == '0);
            default:    acc_err = 1'b1;
        endcase
    end

    // row walk with wrap
    assign last_row   = RW'(eff_rows - 1'b1);
    assign up_row     = (row_reg == '0) ? last_row : row_reg - RW'(1);
    assign dn_row     = (row_reg == last_row) ? '0 : row_reg + RW'(1);
    assign row_in_use = 32'(row_reg) < 32'(eff_rows);
    assign nxt_in_use = (32'(row_reg) + 32'd1) < 32'(eff_rows);
    assign row_last   = (row_reg == RW'(MAX_ROWS - 1));

    lgge_row_next #(
        .MAX_COLS (MAX_COLS)
    ) u_row_next (
        .up_row   (up_reg),
        .cur_row  (cur_reg),
        .dn_row   (ram_rdata),
        .eff_cols (eff_cols),
        .nxt_row  (calc_row)
    );

    lgge_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .wmask (ram_wmask),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (func == FUNC_STEP) && !acc_err)
                begin
                    st_next = ST_RD_UP;
                end
            end
            ST_RD_UP:  st_next = ST_RD_CUR;
            ST_RD_CUR: st_next = ST_RD_DN;
            ST_RD_DN:  st_next = ST_WR_ROW;
            ST_WR_ROW, ST_ZERO_ROW:
            begin
                priority if (row_last)
                begin
                    st_next = ST_IDLE;
                end
                else if (nxt_in_use)
                begin
                    st_next = ST_RD_UP;
                end
                else
                begin
                    st_next = ST_ZERO_ROW;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        row_next     = row_reg;
        up_next      = up_reg;
        cur_next     = cur_reg;
        active_next  = active_reg;
        done_next    = 1'b0;
        status_next  = 1'b0;
        rd_next      = 1'b0;
        col_next     = CW'(col);
        ram_we       = 1'b0;
        ram_waddr    = bank_addr(active_reg, RW'(row));
        ram_raddr    = bank_addr(active_reg, RW'(row));
        ram_wdata    = {MAX_COLS{cell_in}};
        ram_wmask    = '0;
        ram_wmask[CW'(col)] = 1'b1;
        unique case (st_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                ram_wmask    = '1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                row_next = '0;
                if (accept)
                begin
                    // a running advance reports when its last row is written
                    done_next   = !((func == FUNC_STEP) && !acc_err);
                    status_next = acc_err;
                    rd_next     = (func == FUNC_READ) && !acc_err;
                    ram_we      = (func == FUNC_WRITE) && !acc_err;
                end
            end
            ST_RD_UP:
            begin
                ram_raddr = bank_addr(active_reg, up_row);
            end
            ST_RD_CUR:
            begin
                ram_raddr = bank_addr(active_reg, row_reg);
                up_next   = ram_rdata;
            end
            ST_RD_DN:
            begin
                ram_raddr = bank_addr(active_reg, dn_row);
                cur_next  = ram_rdata;
            end
            ST_WR_ROW, ST_ZERO_ROW:
            begin
                ram_we    = 1'b1;
                ram_waddr = bank_addr(!active_reg, row_reg);
                ram_wdata = (st_reg == ST_WR_ROW) ? calc_row : '0;
                ram_wmask = '1;
                row_next  = row_reg + RW'(1);
                if (row_last)
                begin
                    active_next = !active_reg;
                    done_next   = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_CLEAR;
            clr_cnt_reg <= '0;
            row_reg     <= '0;
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
            rd_reg      <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            clr_cnt_reg <= clr_cnt_next;
            row_reg     <= row_next;
            active_reg  <= active_next;
            done_reg    <= done_next;
            rd_reg      <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg     <= up_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        col_reg    <= col_next;
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign cell_out = rd_reg ? ram_rdata[col_reg] : 1'b0;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept) || $past(st_reg == ST_WR_ROW) || $past(st_reg == ST_ZERO_ROW))
        else $error("result strobe without a source beat");

    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(active_reg) |-> done_reg && !status_reg)
        else $error("active bank changed outside a finished advance");

    a_err_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> !cell_out)
        else $error("cell value driven on an error result");

    a_read_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_RD_UP) |-> row_in_use && (eff_cols != '0))
        else $error("advance reading a row outside the area in use");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_CLEAR) |=> !$past(accept))
        else $error("beat accepted during clearing sweep");

endmodule
